// ===== hw/rtl/rcm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared types, constants and helpers of the RMS current meter.
// ----------------------------------------------------------------------------
package rcm_pkg;

    localparam int CODE_W = 16;
    localparam int TIME_W = 32;
    localparam int Q_W = 32;
    localparam int ADC_BITS_W = 5;
    localparam int HZ_W = 10;
    localparam int SUM_W = 64;
    localparam int COUNT_W = 24;
    localparam int TARE_W = 7;
    localparam int MAG_W = 20;
    localparam int SQ_W = 2 * MAG_W;
    localparam int MEAN_W = 40;
    localparam int ROOT_W = SUM_W / 2;
    localparam int GAIN_FRAC = 24;

    localparam int MS_PER_SECOND_INT = 1000;
    localparam int QUOT_W = $clog2(MS_PER_SECOND_INT + 1);
    localparam logic [QUOT_W-1:0] MS_PER_SECOND = QUOT_W'(MS_PER_SECOND_INT);

    localparam int PERIODS_PER_WINDOW_INT = 10;
    localparam int DUR_W = $clog2(100 * MS_PER_SECOND_INT + 1);
    localparam logic [DUR_W-1:0] PERIODS_PER_WINDOW = DUR_W'(PERIODS_PER_WINDOW_INT);

    localparam logic [TARE_W-1:0] TARE_SAMPLES = TARE_W'(100);
    localparam int TRACK_SHIFT = 10;
    localparam int TARE_SHIFT = 2;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int REG_COUNT = 3;
    localparam int PADDR_W = $clog2(4 * (REG_COUNT - 1) + 1);
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_ADC_BITS = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_LINE_HZ = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_GAIN = REG_IDX_W'(2);

    localparam logic [ADC_BITS_W-1:0] ADC_BITS_RESET = ADC_BITS_W'(12);
    localparam logic [HZ_W-1:0] LINE_HZ_RESET = HZ_W'(50);
    localparam logic [Q_W-1:0] GAIN_RESET = Q_W'(13517);

    localparam int UNIT_SRC_W = SUM_W;
    localparam int UNIT_REM_W = ROOT_W + 3;
    localparam int STEP_W = $clog2(UNIT_SRC_W + 1);

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } unit_op_t;

    typedef struct packed {
        logic                    start;
        unit_op_t                op;
        logic [STEP_W-1:0]       steps;
        logic [UNIT_SRC_W-1:0]   src;
        logic [COUNT_W-1:0]      divisor;
    } unit_cmd_t;

    typedef struct packed {
        logic                    done;
        logic [UNIT_SRC_W-1:0]   result;
    } unit_status_t;

    function automatic logic [Q_W-1:0] half_range(input logic [ADC_BITS_W-1:0] bits);
        logic [ADC_BITS_W-1:0] b;
        b = bits;
        if (b < ADC_BITS_W'(8))
        begin
            b = ADC_BITS_W'(8);
        end
        if (b > ADC_BITS_W'(16))
        begin
            b = ADC_BITS_W'(16);
        end
        return Q_W'(1) << (b + ADC_BITS_W'(15));
    endfunction

endpackage

// ===== hw/rtl/rcm_if.sv =====
// ----------------------------------------------------------------------------
// rcm_if
// Valid/ready channels of the RMS current meter: sample items in, results out.
// ----------------------------------------------------------------------------
interface rcm_in_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [rcm_pkg::CODE_W-1:0]  sample_code;
    logic [rcm_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, output req_type, output sample_code, output now_ms,
                    input ready);
    modport sink (input valid, input req_type, input sample_code, input now_ms,
                  output ready);
endinterface

interface rcm_out_if;
    logic                        valid;
    logic                        ready;
    logic                        window_done;
    logic [rcm_pkg::Q_W-1:0]     rms_amps;
    logic [rcm_pkg::Q_W-1:0]     dc_offset;
    logic                        tare_done;

    modport source (output valid, output window_done, output rms_amps, output dc_offset,
                    output tare_done, input ready);
    modport sink (input valid, input window_done, input rms_amps, input dc_offset,
                  input tare_done, output ready);
endinterface

// ===== hw/rtl/rcm_shared_unit.sv =====
// ----------------------------------------------------------------------------
// rcm_shared_unit
// Iterative compare-subtract unit: restoring division or integer square root,
// one quotient or root bit per cycle.
// ----------------------------------------------------------------------------
module rcm_shared_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rcm_pkg::unit_cmd_t    cmd,
    output rcm_pkg::unit_status_t status
);
    import rcm_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [STEP_W-1:0]       count_reg;
    unit_op_t                op_reg;
    logic [UNIT_SRC_W-1:0]   src_reg;
    logic [UNIT_REM_W-1:0]   rem_reg;
    logic [UNIT_SRC_W-1:0]   acc_reg;
    logic [COUNT_W-1:0]      divisor_reg;

    logic [UNIT_REM_W-1:0]   cand;
    logic [UNIT_REM_W-1:0]   trial;
    logic [UNIT_REM_W:0]     diff;
    logic                    fits;
    logic [UNIT_SRC_W-1:0]   src_next;
    logic [UNIT_REM_W-1:0]   rem_next;

    always_comb
    begin
        case (op_reg)
            OP_SQRT:
            begin
                cand     = {rem_reg[UNIT_REM_W-3:0], src_reg[UNIT_SRC_W-1 -: 2]};
                trial    = {1'b0, acc_reg[ROOT_W-1:0], 2'b01};
                src_next = {src_reg[UNIT_SRC_W-3:0], 2'b00};
            end
            default:
            begin
                cand     = {rem_reg[UNIT_REM_W-2:0], src_reg[UNIT_SRC_W-1]};
                trial    = UNIT_REM_W'(divisor_reg);
                src_next = {src_reg[UNIT_SRC_W-2:0], 1'b0};
            end
        endcase
        diff     = {1'b0, cand} - {1'b0, trial};
        fits     = ~diff[UNIT_REM_W];
        rem_next = fits ? diff[UNIT_REM_W-1:0] : cand;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            op_reg    <= OP_DIV;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= cmd.steps;
                op_reg    <= cmd.op;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            src_reg     <= cmd.src;
            rem_reg     <= '0;
            acc_reg     <= '0;
            divisor_reg <= cmd.divisor;
        end
        else if (busy_reg)
        begin
            src_reg <= src_next;
            rem_reg <= rem_next;
            acc_reg <= {acc_reg[UNIT_SRC_W-2:0], fits};
        end
    end

    assign status.done   = done_reg;
    assign status.result = acc_reg;

endmodule

// ===== hw/rtl/rms_current_meter.sv =====
// ----------------------------------------------------------------------------
// rms_current_meter
// True-RMS current meter with DC offset tracking over line-period windows.
// ----------------------------------------------------------------------------
// Items enter on the samples channel (valid/ready): an ADC code with its
// millisecond time, or a tare request. Every accepted item yields one result
// item on the results channel: window flag, last RMS current (Q16.16 A),
// offset estimate (Q16.16 codes) and tare status.
// The block takes one item at a time; samples.ready is high only while idle.
// A tare request goes from idle straight to the finish state, which loads the
// output register. A sample passes the offset, error, square and accumulate
// states and then the 1000/hz division for the window length before its
// result is loaded. A sample that closes a window also runs the 64-step mean
// division and the 32-step square root, then gain scaling and saturation;
// all divisions and the root run on the one shared compare-subtract unit.
// A finished result waits in an output register; the next item is accepted
// meanwhile, and a stall on results holds the block only once a second
// result is ready. Reset loads the register defaults (12 bits, 50 Hz, gain
// 13517), sets the offset to half range and clears all accumulators.
// Write the registers over the APB port only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module rms_current_meter (
    input  logic                          clk,
    input  logic                          rst_n,
    rcm_in_if.sink                        samples,
    rcm_out_if.source                     results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rcm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OFFSET,
        S_ERROR,
        S_SQUARE,
        S_ACCUM,
        S_PERIOD,
        S_PERIOD_WAIT,
        S_CHECK,
        S_MEAN,
        S_MEAN_WAIT,
        S_ROOT,
        S_ROOT_WAIT,
        S_SCALE,
        S_SATURATE,
        S_FINISH
    } state_t;

    state_t                  state_reg;
    logic [ADC_BITS_W-1:0]   adc_bits_reg;
    logic [HZ_W-1:0]         hz_reg;
    logic [Q_W-1:0]          gain_reg;
    logic [Q_W-1:0]          offset_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [TIME_W-1:0]       start_ms_reg;
    logic [Q_W-1:0]          last_rms_reg;
    logic [TARE_W-1:0]       tare_left_reg;
    logic [CODE_W-1:0]       code_reg;
    logic [TIME_W-1:0]       now_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [DUR_W-1:0]        duration_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [2*Q_W-1:0]        product_reg;
    logic                    window_done_reg;
    logic                    out_valid_reg;
    logic                    out_window_done_reg;
    logic [Q_W-1:0]          out_rms_reg;
    logic [Q_W-1:0]          out_offset_reg;
    logic                    out_tare_done_reg;

    logic                    cfg_write;
    logic [REG_IDX_W-1:0]    cfg_index;
    logic [Q_W-1:0]          target;
    logic signed [Q_W:0]     offset_diff;
    logic signed [Q_W:0]     offset_step;
    logic signed [Q_W+1:0]   offset_sum;
    logic [Q_W-1:0]          offset_next;
    logic [Q_W:0]            err_abs;
    logic [SUM_W:0]          sum_wide;
    logic [SUM_W-1:0]        sum_next;
    logic [COUNT_W-1:0]      count_next;
    logic [HZ_W-1:0]         hz_eff;
    logic [DUR_W-1:0]        duration_next;
    logic [TIME_W-1:0]       elapsed;
    logic [MEAN_W-1:0]       mean_sat;
    logic [Q_W-1:0]          amps_sat;
    logic                    out_load;
    unit_cmd_t               unit_cmd;
    unit_status_t            unit_status;

    rcm_shared_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (unit_cmd),
        .status (unit_status)
    );

    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = paddr[PADDR_W-1:2];
    assign pready    = 1'b1;

    always_comb
    begin
        case (cfg_index)
            REG_ADC_BITS: prdata = 32'(adc_bits_reg);
            REG_LINE_HZ:  prdata = 32'(hz_reg);
            REG_GAIN:     prdata = gain_reg;
            default:      prdata = '0;
        endcase
    end

    always_comb
    begin
        target        = {code_reg, 16'b0};
        offset_diff   = $signed({1'b0, target}) - $signed({1'b0, offset_reg});
        offset_step   = (tare_left_reg != '0) ? (offset_diff >>> TARE_SHIFT)
                                              : (offset_diff >>> TRACK_SHIFT);
        offset_sum    = $signed({2'b00, offset_reg}) + $signed({offset_step[Q_W], offset_step});
        offset_next   = offset_sum[Q_W-1:0];
        err_abs       = offset_diff[Q_W] ? (Q_W+1)'(-offset_diff) : (Q_W+1)'(offset_diff);
        sum_wide      = {1'b0, sum_reg} + (SUM_W+1)'(sq_reg);
        sum_next      = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        count_next    = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        hz_eff        = (hz_reg == '0) ? HZ_W'(1) : hz_reg;
        duration_next = DUR_W'(unit_status.result[QUOT_W-1:0]) * PERIODS_PER_WINDOW;
        elapsed       = now_reg - start_ms_reg;
        mean_sat      = (|unit_status.result[SUM_W-1:MEAN_W]) ? '1
                                                              : unit_status.result[MEAN_W-1:0];
        amps_sat      = (|product_reg[2*Q_W-1:Q_W+GAIN_FRAC]) ? '1
                                                              : product_reg[Q_W+GAIN_FRAC-1:GAIN_FRAC];
        out_load      = (state_reg == S_FINISH) && (!out_valid_reg || results.ready);
    end

    always_comb
    begin
        unit_cmd.start   = 1'b0;
        unit_cmd.op      = OP_DIV;
        unit_cmd.steps   = STEP_W'(QUOT_W);
        unit_cmd.src     = {MS_PER_SECOND, (UNIT_SRC_W-QUOT_W)'(0)};
        unit_cmd.divisor = COUNT_W'(hz_eff);
        case (state_reg)
            S_PERIOD:
            begin
                unit_cmd.start = 1'b1;
            end
            S_MEAN:
            begin
                unit_cmd.start   = 1'b1;
                unit_cmd.steps   = STEP_W'(SUM_W);
                unit_cmd.src     = sum_reg;
                unit_cmd.divisor = count_reg;
            end
            S_ROOT:
            begin
                unit_cmd.start = 1'b1;
                unit_cmd.op    = OP_SQRT;
                unit_cmd.steps = STEP_W'(ROOT_W);
                unit_cmd.src   = {mean_sat, (UNIT_SRC_W-MEAN_W)'(0)};
            end
            default:
            begin
                unit_cmd.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            adc_bits_reg        <= ADC_BITS_RESET;
            hz_reg              <= LINE_HZ_RESET;
            gain_reg            <= GAIN_RESET;
            offset_reg          <= half_range(ADC_BITS_RESET);
            sum_reg             <= '0;
            count_reg           <= '0;
            start_ms_reg        <= '0;
            last_rms_reg        <= '0;
            tare_left_reg       <= '0;
            code_reg            <= '0;
            now_reg             <= '0;
            mag_reg             <= '0;
            sq_reg              <= '0;
            duration_reg        <= '0;
            root_reg            <= '0;
            product_reg         <= '0;
            window_done_reg     <= 1'b0;
            out_valid_reg       <= 1'b0;
            out_window_done_reg <= 1'b0;
            out_rms_reg         <= '0;
            out_offset_reg      <= '0;
            out_tare_done_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (samples.valid)
                    begin
                        code_reg        <= samples.sample_code;
                        now_reg         <= samples.now_ms;
                        window_done_reg <= 1'b0;
                        if (samples.req_type)
                        begin
                            tare_left_reg <= TARE_SAMPLES;
                            state_reg     <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_OFFSET;
                        end
                    end
                end
                S_OFFSET:
                begin
                    offset_reg <= offset_next;
                    if (tare_left_reg != '0)
                    begin
                        tare_left_reg <= tare_left_reg - 1'b1;
                    end
                    state_reg <= S_ERROR;
                end
                S_ERROR:
                begin
                    mag_reg   <= err_abs[Q_W-1:Q_W-MAG_W];
                    state_reg <= S_SQUARE;
                end
                S_SQUARE:
                begin
                    sq_reg    <= mag_reg * mag_reg;
                    state_reg <= S_ACCUM;
                end
                S_ACCUM:
                begin
                    if (count_reg == '0)
                    begin
                        start_ms_reg <= now_reg;
                    end
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                    state_reg <= S_PERIOD;
                end
                S_PERIOD:
                begin
                    state_reg <= S_PERIOD_WAIT;
                end
                S_PERIOD_WAIT:
                begin
                    if (unit_status.done)
                    begin
                        duration_reg <= duration_next;
                        state_reg    <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (elapsed >= TIME_W'(duration_reg))
                    begin
                        state_reg <= S_MEAN;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_MEAN:
                begin
                    state_reg <= S_MEAN_WAIT;
                end
                S_MEAN_WAIT:
                begin
                    if (unit_status.done)
                    begin
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    state_reg <= S_ROOT_WAIT;
                end
                S_ROOT_WAIT:
                begin
                    if (unit_status.done)
                    begin
                        root_reg  <= unit_status.result[ROOT_W-1:0];
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    product_reg <= root_reg * gain_reg;
                    state_reg   <= S_SATURATE;
                end
                S_SATURATE:
                begin
                    last_rms_reg    <= amps_sat;
                    sum_reg         <= '0;
                    count_reg       <= '0;
                    window_done_reg <= 1'b1;
                    state_reg       <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_load)
                    begin
                        out_window_done_reg <= window_done_reg;
                        out_rms_reg         <= last_rms_reg;
                        out_offset_reg      <= offset_reg;
                        out_tare_done_reg   <= (tare_left_reg == '0);
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ADC_BITS:
                    begin
                        adc_bits_reg <= pwdata[ADC_BITS_W-1:0];
                        offset_reg   <= half_range(pwdata[ADC_BITS_W-1:0]);
                    end
                    REG_LINE_HZ:
                    begin
                        hz_reg <= pwdata[HZ_W-1:0];
                    end
                    REG_GAIN:
                    begin
                        gain_reg <= pwdata;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign samples.ready       = (state_reg == S_IDLE);
    assign results.valid       = out_valid_reg;
    assign results.window_done = out_window_done_reg;
    assign results.rms_amps    = out_rms_reg;
    assign results.dc_offset   = out_offset_reg;
    assign results.tare_done   = out_tare_done_reg;

endmodule
